@@ src/cst_pkg.sv @@
// Package for the connection slot table: sizes, field widths, codes and
// the controller state type. No dependencies.
package cst_pkg;

  localparam int SLOTS    = 4;
  localparam int SLOT_AW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int FREE_W   = $clog2(SLOTS + 1);

  localparam int ID_W     = 8;
  localparam int STAMP_W  = 32;
  localparam int ENTRY_W  = ID_W + STAMP_W;

  localparam int IDX_W    = 2;
  localparam int FCNT_W   = 3;

  localparam logic MODE_CONNECT    = 1'b0;
  localparam logic MODE_DISCONNECT = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } cst_state_t;

  // Number of clear bits in a busy vector
  function automatic logic [FREE_W-1:0] count_free(input logic [SLOTS-1:0] busy);
    logic [FREE_W-1:0] n;
    n = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!busy[i]) n = n + 1'b1;
    end
    return n;
  endfunction

endpackage

@@ src/cst_in_if.sv @@
// Event channel of the slot table: valid/ready plus the event fields.
// Depends on cst_pkg for field widths.
interface cst_in_if
  import cst_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [ID_W-1:0]    client_id;
  logic [STAMP_W-1:0] now_ms;

  modport source (output valid, mode, client_id, now_ms, input ready);
  modport sink   (input valid, mode, client_id, now_ms, output ready);
endinterface

@@ src/cst_out_if.sv @@
// Result channel of the slot table: valid/ready plus the result fields.
// Depends on cst_pkg for field widths.
interface cst_out_if
  import cst_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  slot_index;
  logic              success;
  logic              evicted;
  logic [ID_W-1:0]   evicted_id;
  logic [FCNT_W-1:0] free_count;

  modport source (output valid, slot_index, success, evicted, evicted_id, free_count,
                  input ready);
  modport sink   (input valid, slot_index, success, evicted, evicted_id, free_count,
                  output ready);
endinterface

@@ src/cst_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

@@ src/connection_slot_table_oldest_evict_core.sv @@
// Connection slot table with oldest-entry eviction: controller and slot RAM.
// Depends on cst_pkg, cst_in_if, cst_out_if and cst_ram.
//
// Use: each transfer on in_ch is one event. A connect (mode 0) places the
// client in the lowest free slot; with the table full it first evicts the
// busy slot of greatest age (now_ms minus stamp, wrapping), highest index on
// a tie, and reports that id. A disconnect (mode 1) frees the lowest busy
// slot whose id matches. Each event gives exactly one result on out_ch.
// Busy flags sit in flops; ids and stamps sit in a one-port-read RAM.
// Events are taken one at a time. A connect that finds a free slot goes
// straight from transfer to its final step; a full-table connect and any
// disconnect first scan the RAM one slot a cycle, as its one read port allows.
// Reset clears every busy flag and empties the output register; the RAM
// needs no clearing. A stalled receiver holds the result in the output
// register; the next event can be taken meanwhile and waits at its final
// step until the output register frees.
module connection_slot_table_oldest_evict_core
  import cst_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  cst_in_if.sink        in_ch,
  cst_out_if.source     out_ch
);

  cst_state_t state_r, state_nxt;

  logic [SLOTS-1:0]   busy_r, busy_nxt;
  logic [SLOT_AW-1:0] cnt_r;
  logic [SLOT_AW-1:0] idx_r;
  logic               mode_r;
  logic [ID_W-1:0]    id_r;
  logic [STAMP_W-1:0] now_r;
  logic [STAMP_W-1:0] best_r;
  logic               found_r;
  logic               ev_r;
  logic [ID_W-1:0]    evid_r;

  logic               out_valid_r;
  logic [IDX_W-1:0]   out_idx_r;
  logic               out_ok_r;
  logic               out_ev_r;
  logic [ID_W-1:0]    out_evid_r;
  logic [FCNT_W-1:0]  out_free_r;

  logic               in_xfer;
  logic               out_free_slot;
  logic               load;
  logic               any_free;
  logic [SLOT_AW-1:0] low_free;
  logic               last_entry;
  logic [SLOT_AW-1:0] rd_addr;
  logic [ENTRY_W-1:0] rd_data;
  logic               ram_we;
  logic [ID_W-1:0]    ent_id;
  logic [STAMP_W-1:0] ent_age;
  logic               ok_fin;

  assign in_xfer       = in_ch.valid && in_ch.ready;
  assign out_free_slot = !out_valid_r || out_ch.ready;
  assign load          = (state_r == S_FIN) && out_free_slot;
  assign any_free      = ~&busy_r;
  assign last_entry    = (cnt_r == SLOT_AW'(SLOTS - 1));
  assign ent_id        = rd_data[ENTRY_W-1 -: ID_W];
  assign ent_age       = now_r - rd_data[STAMP_W-1:0];
  assign ok_fin        = (mode_r == MODE_CONNECT) || found_r;
  assign ram_we        = load && (mode_r == MODE_CONNECT);

  always_comb begin
    low_free = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!busy_r[i]) low_free = SLOT_AW'(i);
    end
  end

  // Read slot 0 on the transfer, then the next slot each scan cycle
  assign rd_addr = (state_r == S_SCAN) ? cnt_r + 1'b1 : '0;

  cst_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata ({id_r, now_r}),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_comb begin
    busy_nxt = busy_r;
    if (mode_r == MODE_CONNECT) begin
      busy_nxt[idx_r] = 1'b1;
    end else if (found_r) begin
      busy_nxt[idx_r] = 1'b0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_ch.mode == MODE_CONNECT && any_free) state_nxt = S_FIN;
          else                                        state_nxt = S_SCAN;
        end
      end
      S_SCAN:  if (last_entry) state_nxt = S_FIN;
      S_FIN:   if (out_free_slot) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        busy_r      <= busy_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mode_r  <= in_ch.mode;
      id_r    <= in_ch.client_id;
      now_r   <= in_ch.now_ms;
      cnt_r   <= '0;
      best_r  <= '0;
      found_r <= 1'b0;
      evid_r  <= '0;
      ev_r    <= (in_ch.mode == MODE_CONNECT) && !any_free;
      idx_r   <= (in_ch.mode == MODE_CONNECT && any_free) ? low_free : '0;
    end else if (state_r == S_SCAN) begin
      cnt_r <= cnt_r + 1'b1;
      if (mode_r == MODE_CONNECT) begin
        // Later slots win ties, so compare with >=
        if (ent_age >= best_r) begin
          best_r <= ent_age;
          idx_r  <= cnt_r;
          evid_r <= ent_id;
        end
      end else if (!found_r && busy_r[cnt_r] && ent_id == id_r) begin
        found_r <= 1'b1;
        idx_r   <= cnt_r;
      end
    end
    if (load) begin
      out_idx_r  <= IDX_W'(idx_r);
      out_ok_r   <= ok_fin;
      out_ev_r   <= ev_r;
      out_evid_r <= evid_r;
      out_free_r <= FCNT_W'(count_free(busy_nxt));
    end
  end

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.slot_index = out_idx_r;
  assign out_ch.success    = out_ok_r;
  assign out_ch.evicted    = out_ev_r;
  assign out_ch.evicted_id = out_evid_r;
  assign out_ch.free_count = out_free_r;

  // The reported free count always matches the busy flags it was built from
  a_free_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_free_r == FCNT_W'(count_free(busy_r)))
    else $error("free_count out of step with busy flags");

  // Eviction only ever happens on a full table
  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    (load && ev_r) |-> &busy_r)
    else $error("eviction with a free slot present");

  // A connect leaves its slot busy
  a_connect_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (load && mode_r == MODE_CONNECT) |=> busy_r[$past(idx_r)])
    else $error("connected slot not marked busy");

  // A matched disconnect frees a slot that was busy
  a_disc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (load && mode_r == MODE_DISCONNECT && found_r) |-> busy_r[idx_r])
    else $error("disconnect matched a free slot");

  // The scan never runs past the last slot
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (cnt_r <= SLOT_AW'(SLOTS - 1)))
    else $error("scan counter beyond table");

endmodule

@@ dv/connection_slot_table_oldest_evict_core_test.sv @@
// Testbench for the connection slot table: a directed event table, then random
// connect/disconnect traffic, each result checked against a slot table predictor or a typed-in result.
// Depends on cst_pkg, cst_in_if, cst_out_if and connection_slot_table_oldest_evict_core.
module connection_slot_table_oldest_evict_core_test
  import cst_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 2 * SLOTS + 12;
  localparam int RANDOM_EVENTS = 1400;
  localparam int DIRECTED_ROWS = 22;

  typedef struct packed {
    logic [IDX_W-1:0]  slot_index;
    logic              success;
    logic              evicted;
    logic [ID_W-1:0]   evicted_id;
    logic [FCNT_W-1:0] free_count;
  } outcome_t;

  typedef struct packed {
    logic               mode;
    logic [ID_W-1:0]    client_id;
    logic [STAMP_W-1:0] now_ms;
  } conn_event_t;

  typedef struct packed {
    conn_event_t ev;
    logic        given;
    outcome_t    want;
  } event_row_t;

  localparam outcome_t NO_WANT = '0;

  // Rows with given set carry a result typed in by hand; the rest use the predictor.
  event_row_t event_tbl [DIRECTED_ROWS] = '{
    '{'{MODE_DISCONNECT, 8'h00, 32'h0000_0000}, 1'b1, '{2'd0, 1'b0, 1'b0, 8'h00, 3'd4}},
    '{'{MODE_CONNECT,    8'h00, 32'h0000_0000}, 1'b1, '{2'd0, 1'b1, 1'b0, 8'h00, 3'd3}},
    '{'{MODE_CONNECT,    8'hFF, 32'hFFFF_FFFF}, 1'b1, '{2'd1, 1'b1, 1'b0, 8'h00, 3'd2}},
    '{'{MODE_CONNECT,    8'hAA, 32'h0000_0005}, 1'b1, '{2'd2, 1'b1, 1'b0, 8'h00, 3'd1}},
    '{'{MODE_CONNECT,    8'h55, 32'h0000_0005}, 1'b1, '{2'd3, 1'b1, 1'b0, 8'h00, 3'd0}},
    // full table: eviction across the time wrap, then a two-way age tie
    '{'{MODE_CONNECT,    8'h11, 32'h0000_000A}, 1'b0, NO_WANT},
    '{'{MODE_CONNECT,    8'h22, 32'h0000_0014}, 1'b0, NO_WANT},
    '{'{MODE_CONNECT,    8'h33, 32'h0000_001E}, 1'b0, NO_WANT},
    '{'{MODE_DISCONNECT, 8'hAA, 32'h0000_001F}, 1'b0, NO_WANT},
    // freed slot still holds the id: must not match
    '{'{MODE_DISCONNECT, 8'hAA, 32'h0000_0020}, 1'b0, NO_WANT},
    // duplicate connect, then two disconnects of the same id
    '{'{MODE_CONNECT,    8'h11, 32'h0000_0021}, 1'b0, NO_WANT},
    '{'{MODE_DISCONNECT, 8'h11, 32'h0000_0022}, 1'b0, NO_WANT},
    '{'{MODE_DISCONNECT, 8'h11, 32'h0000_0023}, 1'b0, NO_WANT},
    '{'{MODE_DISCONNECT, 8'h22, 32'h0000_0024}, 1'b0, NO_WANT},
    '{'{MODE_DISCONNECT, 8'h33, 32'h0000_0025}, 1'b0, NO_WANT},
    '{'{MODE_CONNECT,    8'h80, 32'h8000_0000}, 1'b0, NO_WANT},
    '{'{MODE_CONNECT,    8'h7F, 32'h7FFF_FFFF}, 1'b0, NO_WANT},
    '{'{MODE_CONNECT,    8'h01, 32'h8000_0000}, 1'b0, NO_WANT},
    '{'{MODE_CONNECT,    8'hFE, 32'hFFFF_FFFE}, 1'b0, NO_WANT},
    // ages near half the time range decide the victim
    '{'{MODE_CONNECT,    8'h02, 32'h0000_0000}, 1'b0, NO_WANT},
    '{'{MODE_CONNECT,    8'h03, 32'hFFFF_FFFF}, 1'b0, NO_WANT},
    '{'{MODE_DISCONNECT, 8'h5A, 32'h0000_0001}, 1'b0, NO_WANT}
  };

  logic clk;
  logic rst_n;

  cst_in_if  ev_ch ();
  cst_out_if res_ch ();

  connection_slot_table_oldest_evict_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (ev_ch),
    .out_ch (res_ch)
  );

  logic               model_busy   [SLOTS];
  logic [ID_W-1:0]    model_client [SLOTS];
  logic [STAMP_W-1:0] model_stamp  [SLOTS];

  outcome_t           pending_q [$];
  int unsigned        err_count    = 0;
  int unsigned        cycle_count  = 0;
  int unsigned        src_idle_pct = 0;
  int unsigned        snk_idle_pct = 0;
  logic [ID_W-1:0]    pool_base    = '0;
  logic [STAMP_W-1:0] clock_ms     = '0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Apply one event to the slot table copy and return the result it gives.
  function automatic outcome_t apply_event(input conn_event_t ev);
    outcome_t           r;
    logic [STAMP_W-1:0] age;
    logic [STAMP_W-1:0] oldest;
    int                 slot;
    int                 n_free;
    r      = '0;
    slot   = -1;
    oldest = '0;
    n_free = 0;
    if (ev.mode == MODE_CONNECT) begin
      for (int i = SLOTS - 1; i >= 0; i--) begin
        if (!model_busy[i]) slot = i;
      end
      if (slot < 0) begin
        // greatest age wins, a later slot takes a tie
        slot = 0;
        for (int i = 0; i < SLOTS; i++) begin
          age = ev.now_ms - model_stamp[i];
          if (age >= oldest) begin
            oldest = age;
            slot   = i;
          end
        end
        r.evicted    = 1'b1;
        r.evicted_id = model_client[slot];
      end
      model_busy[slot]   = 1'b1;
      model_client[slot] = ev.client_id;
      model_stamp[slot]  = ev.now_ms;
      r.success          = 1'b1;
      r.slot_index       = slot[IDX_W-1:0];
    end else begin
      for (int i = 0; i < SLOTS; i++) begin
        if (slot < 0 && model_busy[i] && model_client[i] == ev.client_id) slot = i;
      end
      if (slot >= 0) begin
        model_busy[slot] = 1'b0;
        r.success        = 1'b1;
        r.slot_index     = slot[IDX_W-1:0];
      end
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (!model_busy[i]) n_free++;
    end
    r.free_count = n_free[FCNT_W-1:0];
    return r;
  endfunction

  // Mostly ids from a small pool so disconnects find their clients; time
  // creeps forward with the odd repeat, big step, wrap or jump.
  function automatic conn_event_t random_event();
    conn_event_t ev;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 55) begin
      clock_ms += $urandom_range(3);
    end else if (pick < 90) begin
      clock_ms += $urandom_range(2000);
    end else if (pick < 95) begin
      clock_ms = 32'hFFFF_FFFF - $urandom_range(40);
    end else begin
      clock_ms = $urandom();
    end
    ev.now_ms    = clock_ms;
    ev.mode      = ($urandom_range(99) < 52) ? MODE_CONNECT : MODE_DISCONNECT;
    ev.client_id = ($urandom_range(99) < 85) ? ID_W'(pool_base + $urandom_range(5))
                                              : ID_W'($urandom_range(255));
    return ev;
  endfunction

  task automatic send_event(input conn_event_t ev, input logic given, input outcome_t want);
    outcome_t predicted;
    while ($urandom_range(99) < src_idle_pct) begin
      ev_ch.valid <= 1'b0;
      @(posedge clk);
    end
    ev_ch.valid     <= 1'b1;
    ev_ch.mode      <= ev.mode;
    ev_ch.client_id <= ev.client_id;
    ev_ch.now_ms    <= ev.now_ms;
    @(posedge clk);
    while (ev_ch.ready !== 1'b1) @(posedge clk);
    predicted = apply_event(ev);
    pending_q.push_back(given ? want : predicted);
  endtask

  // Result side: check each transfer, then pick the next ready level.
  initial begin
    outcome_t got;
    outcome_t want;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
        got.slot_index = res_ch.slot_index;
        got.success    = res_ch.success;
        got.evicted    = res_ch.evicted;
        got.evicted_id = res_ch.evicted_id;
        got.free_count = res_ch.free_count;
        if (pending_q.size() == 0) begin
          $error("result transfer with no event outstanding");
          err_count++;
        end else begin
          want = pending_q.pop_front();
          if (got.slot_index !== want.slot_index) begin
            $error("slot_index: expected %0d, got %0d", want.slot_index, got.slot_index);
            err_count++;
          end
          if (got.success !== want.success) begin
            $error("success: expected %0d, got %0d", want.success, got.success);
            err_count++;
          end
          if (got.evicted !== want.evicted) begin
            $error("evicted: expected %0d, got %0d", want.evicted, got.evicted);
            err_count++;
          end
          if (got.evicted_id !== want.evicted_id) begin
            $error("evicted_id: expected 0x%02h, got 0x%02h", want.evicted_id, got.evicted_id);
            err_count++;
          end
          if (got.free_count !== want.free_count) begin
            $error("free_count: expected %0d, got %0d", want.free_count, got.free_count);
            err_count++;
          end
        end
      end
      res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  initial begin
    rst_n           = 1'b0;
    ev_ch.valid     = 1'b0;
    ev_ch.mode      = MODE_CONNECT;
    ev_ch.client_id = '0;
    ev_ch.now_ms    = '0;
    for (int i = 0; i < SLOTS; i++) begin
      model_busy[i]   = 1'b0;
      model_client[i] = '0;
      model_stamp[i]  = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    src_idle_pct = 17;
    snk_idle_pct = 67;
    foreach (event_tbl[k]) send_event(event_tbl[k].ev, event_tbl[k].given, event_tbl[k].want);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct = 17;
          snk_idle_pct = 67;
        end
        1: begin
          src_idle_pct = 67;
          snk_idle_pct = 17;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      pool_base = ID_W'($urandom_range(255));
      clock_ms  = $urandom();
      repeat (RANDOM_EVENTS / 3) send_event(random_event(), 1'b0, NO_WANT);
    end
    ev_ch.valid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
